// ----- design/obcc_pkg.sv -----
package obcc_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 16;
  localparam logic [31:0] TOL_RESET = 32'd43;
  localparam logic [15:0] NORM_ONE = 16'd16384;

  typedef struct packed {
    logic [31:0] box_center_x;
    logic [31:0] box_center_y;
    logic [30:0] box_half_width;
    logic [30:0] box_half_height;
    logic [15:0] box_cosine;
    logic [15:0] box_sine;
    logic [31:0] circle_center_x;
    logic [31:0] circle_center_y;
    logic [30:0] circle_radius;
  } in_beat_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] impact_x;
    logic [31:0] impact_y;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
  } out_beat_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] impact_x;
    logic [31:0] impact_y;
    logic        zero;
    logic        neg_x;
    logic        neg_y;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [30:0] ax;
    logic [30:0] ay;
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    meta_t       meta;
    logic [31:0] len;
    logic [46:0] rem_x;
    logic [46:0] rem_y;
    logic [15:0] q_x;
    logic [15:0] q_y;
  } dv_t;

endpackage

// ----- design/oriented_box_circle_collision.sv -----
// Oriented box versus circle test, fully pipelined: one beat is taken every cycle
// (busy is always low) and its result strobes out in order after passing the
// stages of the normal path: 11 stages of offset, rotation, clamp, hit test,
// world transform and normalization, 32 stages of the bit-per-stage square root,
// 16 stages of the bit-per-stage divider and one output register. The tolerance
// register is read at stage 8, so write it only while no beat is in flight.
module oriented_box_circle_collision (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  obcc_pkg::in_beat_t   in_beat,
  output logic                 out_strobe,
  output obcc_pkg::out_beat_t  out_beat,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);
  import obcc_pkg::*;

  localparam int LATENCY = 11 + SQRT_STEPS + DIV_STEPS + 1;

  logic [31:0] tol_r;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r;
  in_beat_t           in1_r, in2_r, in3_r, in4_r, in5_r, in6_r;
  logic signed [32:0] dx1_r, dy1_r, dx_nxt, dy_nxt;
  logic signed [48:0] cdx2_r, sdy2_r, cdy2_r, sdx2_r;
  logic signed [35:0] lx3_r, ly3_r;
  logic signed [49:0] lsx_nxt, lsy_nxt;
  logic signed [31:0] px4_r, py4_r;
  logic [36:0]        gx4_r, gy4_r, gx_nxt, gy_nxt;
  logic signed [36:0] lxe_nxt, lye_nxt, exs_nxt, eys_nxt, pxe_nxt, pye_nxt, dgx_nxt, dgy_nxt;
  logic               ok5_r;
  logic [61:0]        gxx5_r, gyy5_r, rr5_r;
  logic signed [47:0] cpx5_r, spy5_r, spx5_r, cpy5_r;
  logic               hit6_r;
  logic signed [35:0] wx6_r, wy6_r;
  logic signed [49:0] wsx_nxt, wsy_nxt;
  meta_t              meta7_r, meta8_r, meta9_r, meta10_r, meta11_r, meta7_nxt, meta8_nxt;
  logic [36:0]        ax7_r, ay7_r, ax8_r, ay8_r, ax_nxt, ay_nxt, m_nxt;
  logic signed [36:0] nx_nxt, ny_nxt;
  logic [5:0]         msb8_r, msb_nxt;
  logic [32:0]        small_sq_nxt;
  logic [30:0]        ax9_r, ay9_r, ax10_r, ay10_r, ax11_r, ay11_r, ax9_nxt, ay9_nxt;
  logic [61:0]        axx10_r, ayy10_r;
  logic [62:0]        sum11_r;

  logic               sq_v_r [SQRT_STEPS];
  sq_t                sq_r   [SQRT_STEPS];
  logic               dv_v_r [DIV_STEPS];
  dv_t                dv_r   [DIV_STEPS];

  logic               out_strobe_r;
  out_beat_t          out_beat_r, out_nxt;
  logic [16:0]        qx_nxt, qy_nxt;
  logic [15:0]        mx_nxt, my_nxt;

  assign busy = 1'b0;
  assign out_strobe = out_strobe_r;
  assign out_beat = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  always_comb begin
    dx_nxt = {in_beat.circle_center_x[31], in_beat.circle_center_x}
           - {in_beat.box_center_x[31], in_beat.box_center_x};
    dy_nxt = {in_beat.circle_center_y[31], in_beat.circle_center_y}
           - {in_beat.box_center_y[31], in_beat.box_center_y};

    lsx_nxt = {cdx2_r[48], cdx2_r} + {sdy2_r[48], sdy2_r} + 50'sd8192;
    lsy_nxt = {cdy2_r[48], cdy2_r} - {sdx2_r[48], sdx2_r} + 50'sd8192;

    lxe_nxt = {lx3_r[35], lx3_r};
    lye_nxt = {ly3_r[35], ly3_r};
    exs_nxt = {6'd0, in3_r.box_half_width};
    eys_nxt = {6'd0, in3_r.box_half_height};
    if (lxe_nxt > exs_nxt) pxe_nxt = exs_nxt;
    else if (lxe_nxt < -exs_nxt) pxe_nxt = -exs_nxt;
    else pxe_nxt = lxe_nxt;
    if (lye_nxt > eys_nxt) pye_nxt = eys_nxt;
    else if (lye_nxt < -eys_nxt) pye_nxt = -eys_nxt;
    else pye_nxt = lye_nxt;
    dgx_nxt = lxe_nxt - pxe_nxt;
    dgy_nxt = lye_nxt - pye_nxt;
    gx_nxt = dgx_nxt[36] ? 37'(-dgx_nxt) : 37'(dgx_nxt);
    gy_nxt = dgy_nxt[36] ? 37'(-dgy_nxt) : 37'(dgy_nxt);

    wsx_nxt = {{2{cpx5_r[47]}}, cpx5_r} - {{2{spy5_r[47]}}, spy5_r}
            + {{4{in5_r.box_center_x[31]}}, in5_r.box_center_x, 14'd0} + 50'sd8192;
    wsy_nxt = {{2{spx5_r[47]}}, spx5_r} + {{2{cpy5_r[47]}}, cpy5_r}
            + {{4{in5_r.box_center_y[31]}}, in5_r.box_center_y, 14'd0} + 50'sd8192;

    meta7_nxt = '0;
    meta7_nxt.hit = hit6_r;
    if (hit6_r) begin
      if (wx6_r > 36'sh07fffffff) meta7_nxt.impact_x = 32'h7fffffff;
      else if (wx6_r < -36'sh080000000) meta7_nxt.impact_x = 32'h80000000;
      else meta7_nxt.impact_x = wx6_r[31:0];
      if (wy6_r > 36'sh07fffffff) meta7_nxt.impact_y = 32'h7fffffff;
      else if (wy6_r < -36'sh080000000) meta7_nxt.impact_y = 32'h80000000;
      else meta7_nxt.impact_y = wy6_r[31:0];
    end
    nx_nxt = {{5{in6_r.circle_center_x[31]}}, in6_r.circle_center_x} - {wx6_r[35], wx6_r};
    ny_nxt = {{5{in6_r.circle_center_y[31]}}, in6_r.circle_center_y} - {wy6_r[35], wy6_r};
    meta7_nxt.neg_x = nx_nxt[36];
    meta7_nxt.neg_y = ny_nxt[36];
    ax_nxt = nx_nxt[36] ? 37'(-nx_nxt) : 37'(nx_nxt);
    ay_nxt = ny_nxt[36] ? 37'(-ny_nxt) : 37'(ny_nxt);

    meta8_nxt = meta7_r;
    small_sq_nxt = 33'(ax7_r[15:0] * ax7_r[15:0]) + 33'(ay7_r[15:0] * ay7_r[15:0]);
    meta8_nxt.zero = ((ax7_r == '0) && (ay7_r == '0))
                  || ((ax7_r[36:16] == '0) && (ay7_r[36:16] == '0)
                      && (small_sq_nxt < {1'b0, tol_r}));
    m_nxt = ax7_r | ay7_r;
    msb_nxt = '0;
    for (int i = 0; i < 37; i++) begin
      if (m_nxt[i]) msb_nxt = 6'(i);
    end

    if (msb8_r >= 6'd30) begin
      ax9_nxt = 31'(ax8_r >> (msb8_r - 6'd30));
      ay9_nxt = 31'(ay8_r >> (msb8_r - 6'd30));
    end else begin
      ax9_nxt = 31'(ax8_r << (6'd30 - msb8_r));
      ay9_nxt = 31'(ay8_r << (6'd30 - msb8_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
    end
    in1_r <= in_beat;
    dx1_r <= dx_nxt;
    dy1_r <= dy_nxt;

    in2_r <= in1_r;
    cdx2_r <= $signed(in1_r.box_cosine) * dx1_r;
    sdy2_r <= $signed(in1_r.box_sine) * dy1_r;
    cdy2_r <= $signed(in1_r.box_cosine) * dy1_r;
    sdx2_r <= $signed(in1_r.box_sine) * dx1_r;

    in3_r <= in2_r;
    lx3_r <= lsx_nxt[49:14];
    ly3_r <= lsy_nxt[49:14];

    in4_r <= in3_r;
    px4_r <= pxe_nxt[31:0];
    py4_r <= pye_nxt[31:0];
    gx4_r <= gx_nxt;
    gy4_r <= gy_nxt;

    in5_r <= in4_r;
    ok5_r <= (gx4_r <= {6'd0, in4_r.circle_radius}) && (gy4_r <= {6'd0, in4_r.circle_radius});
    gxx5_r <= gx4_r[30:0] * gx4_r[30:0];
    gyy5_r <= gy4_r[30:0] * gy4_r[30:0];
    rr5_r <= in4_r.circle_radius * in4_r.circle_radius;
    cpx5_r <= $signed(in4_r.box_cosine) * px4_r;
    spy5_r <= $signed(in4_r.box_sine) * py4_r;
    spx5_r <= $signed(in4_r.box_sine) * px4_r;
    cpy5_r <= $signed(in4_r.box_cosine) * py4_r;

    in6_r <= in5_r;
    hit6_r <= ok5_r && ((63'(gxx5_r) + 63'(gyy5_r)) <= 63'(rr5_r));
    wx6_r <= wsx_nxt[49:14];
    wy6_r <= wsy_nxt[49:14];

    meta7_r <= meta7_nxt;
    ax7_r <= ax_nxt;
    ay7_r <= ay_nxt;

    meta8_r <= meta8_nxt;
    ax8_r <= ax7_r;
    ay8_r <= ay7_r;
    msb8_r <= msb_nxt;

    meta9_r <= meta8_r;
    ax9_r <= ax9_nxt;
    ay9_r <= ay9_nxt;

    meta10_r <= meta9_r;
    ax10_r <= ax9_r;
    ay10_r <= ay9_r;
    axx10_r <= ax9_r * ax9_r;
    ayy10_r <= ay9_r * ay9_r;

    meta11_r <= meta10_r;
    ax11_r <= ax10_r;
    ay11_r <= ay10_r;
    sum11_r <= 63'(axx10_r) + 63'(ayy10_r);
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int B = SQRT_STEPS - 1 - k;
    sq_t         src;
    logic        src_v;
    sq_t         sq_nxt;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign src = '{meta: meta11_r, ax: ax11_r, ay: ay11_r,
                     rem: {1'b0, sum11_r}, root: '0};
      assign src_v = v11_r;
    end else begin : g_next
      assign src = sq_r[k-1];
      assign src_v = sq_v_r[k-1];
    end

    always_comb begin
      sq_nxt = src;
      trial = (64'(src.root) << (B + 1)) | (64'd1 << (2 * B));
      if (src.rem >= trial) begin
        sq_nxt.rem = src.rem - trial;
        sq_nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else begin
        sq_v_r[k] <= src_v;
      end
      sq_r[k] <= sq_nxt;
    end
  end

  // restoring divide of both components by the length, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    dv_t         src;
    logic        src_v;
    dv_t         dv_nxt;
    logic [46:0] dsub;

    if (k == 0) begin : g_first
      assign src = '{meta: sq_r[SQRT_STEPS-1].meta, len: sq_r[SQRT_STEPS-1].root,
                     rem_x: {1'b0, sq_r[SQRT_STEPS-1].ax, 15'd0},
                     rem_y: {1'b0, sq_r[SQRT_STEPS-1].ay, 15'd0},
                     q_x: '0, q_y: '0};
      assign src_v = sq_v_r[SQRT_STEPS-1];
    end else begin : g_next
      assign src = dv_r[k-1];
      assign src_v = dv_v_r[k-1];
    end

    always_comb begin
      dv_nxt = src;
      dsub = 47'(src.len) << B;
      if (src.rem_x >= dsub) begin
        dv_nxt.rem_x = src.rem_x - dsub;
        dv_nxt.q_x[B] = 1'b1;
      end
      if (src.rem_y >= dsub) begin
        dv_nxt.rem_y = src.rem_y - dsub;
        dv_nxt.q_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else begin
        dv_v_r[k] <= src_v;
      end
      dv_r[k] <= dv_nxt;
    end
  end

  always_comb begin
    qx_nxt = ({1'b0, dv_r[DIV_STEPS-1].q_x} + 17'd1) >> 1;
    qy_nxt = ({1'b0, dv_r[DIV_STEPS-1].q_y} + 17'd1) >> 1;
    mx_nxt = (qx_nxt > 17'(NORM_ONE)) ? NORM_ONE : qx_nxt[15:0];
    my_nxt = (qy_nxt > 17'(NORM_ONE)) ? NORM_ONE : qy_nxt[15:0];
    out_nxt.hit = dv_r[DIV_STEPS-1].meta.hit;
    out_nxt.impact_x = dv_r[DIV_STEPS-1].meta.impact_x;
    out_nxt.impact_y = dv_r[DIV_STEPS-1].meta.impact_y;
    if (dv_r[DIV_STEPS-1].meta.hit && !dv_r[DIV_STEPS-1].meta.zero) begin
      out_nxt.normal_x = dv_r[DIV_STEPS-1].meta.neg_x ? -mx_nxt : mx_nxt;
      out_nxt.normal_y = dv_r[DIV_STEPS-1].meta.neg_y ? -my_nxt : my_nxt;
    end else begin
      out_nxt.normal_x = '0;
      out_nxt.normal_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_v_r[DIV_STEPS-1];
    end
    out_beat_r <= out_nxt;
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LATENCY))
    else $error("result beat without a matching accepted beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_beat.hit) |->
      (out_beat.impact_x == '0 && out_beat.impact_y == '0 &&
       out_beat.normal_x == '0 && out_beat.normal_y == '0))
    else $error("miss beat carries nonzero impact or normal");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($signed(out_beat.normal_x) <= $signed(NORM_ONE) &&
                    $signed(out_beat.normal_x) >= -$signed(NORM_ONE) &&
                    $signed(out_beat.normal_y) <= $signed(NORM_ONE) &&
                    $signed(out_beat.normal_y) >= -$signed(NORM_ONE)))
    else $error("normal component beyond unit magnitude");
`endif

endmodule

// ----- tb/obcc_checker.sv -----
`timescale 1ns / 1ps

module obcc_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  obcc_pkg::in_beat_t   in_beat,
  input  logic                 out_strobe,
  input  obcc_pkg::out_beat_t  out_beat,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  output int                   errors,
  output int                   pending
);
  import obcc_pkg::*;

  logic [31:0] tolerance;
  out_beat_t   collision_q[$];

  function automatic longint round_q14(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // returns {normal_x, normal_y}
  function automatic logic [31:0] unit_normal(longint nx, longint ny, logic [31:0] tol);
    longint unsigned ax, ay, m, len, qx, qy;
    logic [15:0] ox, oy;
    ax = nx < 0 ? longint'(-nx) : nx;
    ay = ny < 0 ? longint'(-ny) : ny;
    if (ax == 0 && ay == 0) return 32'd0;
    if (ax < 65536 && ay < 65536 && ax * ax + ay * ay < {32'd0, tol}) return 32'd0;
    m = ax | ay;
    while (m >= (64'd1 << 31)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    len = floor_sqrt(ax * ax + ay * ay);
    qx = (((ax << 15) / len) + 1) >> 1;
    qy = (((ay << 15) / len) + 1) >> 1;
    if (qx > 16384) qx = 16384;
    if (qy > 16384) qy = 16384;
    ox = nx < 0 ? 16'(-qx) : 16'(qx);
    oy = ny < 0 ? 16'(-qy) : 16'(qy);
    return {ox, oy};
  endfunction

  function automatic out_beat_t predict_collision(in_beat_t b, logic [31:0] tol);
    longint bx, by, ex, ey, c, s, cx, cy, r, dx, dy, lx, ly, px, py, wx, wy;
    longint unsigned gx, gy;
    logic [31:0] nrm;
    out_beat_t o;
    bx = longint'($signed(b.box_center_x));
    by = longint'($signed(b.box_center_y));
    ex = longint'(b.box_half_width);
    ey = longint'(b.box_half_height);
    c  = longint'($signed(b.box_cosine));
    s  = longint'($signed(b.box_sine));
    cx = longint'($signed(b.circle_center_x));
    cy = longint'($signed(b.circle_center_y));
    r  = longint'(b.circle_radius);
    dx = cx - bx;
    dy = cy - by;
    lx = round_q14(c * dx + s * dy);
    ly = round_q14(c * dy - s * dx);
    px = clamp_range(lx, -ex, ex);
    py = clamp_range(ly, -ey, ey);
    gx = (lx - px) < 0 ? longint'(px - lx) : lx - px;
    gy = (ly - py) < 0 ? longint'(py - ly) : ly - py;
    o = '0;
    if (gx <= r && gy <= r)
      o.hit = (gx * gx + gy * gy) <= longint'(r) * longint'(r);
    if (o.hit) begin
      wx = round_q14(c * px - s * py + bx * 16384);
      wy = round_q14(s * px + c * py + by * 16384);
      o.impact_x = 32'(clamp_range(wx, -(64'sd1 << 31), (64'sd1 << 31) - 1));
      o.impact_y = 32'(clamp_range(wy, -(64'sd1 << 31), (64'sd1 << 31) - 1));
      nrm = unit_normal(cx - wx, cy - wy, tol);
      o.normal_x = nrm[31:16];
      o.normal_y = nrm[15:0];
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      tolerance = TOL_RESET;
      errors = 0;
    end else begin
      if (out_strobe) begin
        if (collision_q.size() == 0) begin
          report("unexpected beat", 32'd0, 32'd0);
        end else begin
          want = collision_q.pop_front();
          if (out_beat.hit !== want.hit)
            report("hit", 32'(out_beat.hit), 32'(want.hit));
          if (out_beat.impact_x !== want.impact_x)
            report("impact_x", out_beat.impact_x, want.impact_x);
          if (out_beat.impact_y !== want.impact_y)
            report("impact_y", out_beat.impact_y, want.impact_y);
          if (out_beat.normal_x !== want.normal_x)
            report("normal_x", 32'(out_beat.normal_x), 32'(want.normal_x));
          if (out_beat.normal_y !== want.normal_y)
            report("normal_y", 32'(out_beat.normal_y), 32'(want.normal_y));
        end
      end
      if (start && !busy) collision_q.push_back(predict_collision(in_beat, tolerance));
      if (cfg_we) tolerance = cfg_wdata;
    end
    pending = collision_q.size();
  end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import obcc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN = 80;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  in_beat_t    in_beat = '0;
  logic        out_strobe;
  out_beat_t   out_beat;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  int          errors, pending, cycles = 0;
  bit          steady = 0;

  always #10 clk = ~clk;

  oriented_box_circle_collision dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_strobe(out_strobe), .out_beat(out_beat), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  obcc_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_strobe(out_strobe), .out_beat(out_beat), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // called and returns at a falling edge
  task automatic send_query(in_beat_t b);
    while (!steady && $urandom_range(0, 99) < 9) begin
      start <= 0;
      @(posedge clk);
      @(negedge clk);
    end
    start <= 1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic settle_and_write(logic [31:0] tol);
    start <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= tol;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic in_beat_t query(longint bx, longint by, longint ex, longint ey,
                                     longint c, longint s, longint cx, longint cy,
                                     longint r);
    in_beat_t b;
    b.box_center_x = 32'(bx);
    b.box_center_y = 32'(by);
    b.box_half_width = 31'(ex);
    b.box_half_height = 31'(ey);
    b.box_cosine = 16'(c);
    b.box_sine = 16'(s);
    b.circle_center_x = 32'(cx);
    b.circle_center_y = 32'(cy);
    b.circle_radius = 31'(r);
    return b;
  endfunction

  function automatic longint scaled_rand(int k);
    return longint'({$urandom, $urandom}) & ((64'sd1 << k) - 1);
  endfunction

  function automatic in_beat_t random_query();
    in_beat_t b;
    longint bx, by, ex, ey, c, s, r;
    int k;
    real ang;
    if ($urandom_range(0, 99) < 10) begin
      b = 253'({$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(0, 1)) b.box_cosine = 16'($signed(16'(b.box_cosine)) % 16385);
      if ($urandom_range(0, 1)) b.box_sine = 16'($signed(16'(b.box_sine)) % 16385);
      return b;
    end
    k = $urandom_range(2, 30);
    bx = longint'($signed($urandom));
    by = longint'($signed($urandom));
    if ($urandom_range(0, 3) == 0) begin
      bx = bx >>> 8;
      by = by >>> 8;
    end
    ex = scaled_rand(k);
    ey = scaled_rand(k);
    r = scaled_rand(k);
    if ($urandom_range(0, 9) == 0) begin
      c = $signed(16'($urandom_range(0, 32768) - 16384));
      s = $signed(16'($urandom_range(0, 32768) - 16384));
    end else begin
      ang = $urandom_range(0, 62831) / 10000.0;
      c = longint'($rtoi($cos(ang) * 16384.0));
      s = longint'($rtoi($sin(ang) * 16384.0));
    end
    return query(bx, by, ex, ey, c, s,
                 bx + scaled_rand(k + 1) - (64'sd1 << k),
                 by + scaled_rand(k + 1) - (64'sd1 << k), r);
  endfunction

  initial begin
    longint maxp, minp;
    maxp = 64'sd2147483647;
    minp = -64'sd2147483648;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed beats at reset tolerance
    send_query(query(0, 0, 0, 0, 16384, 0, 0, 0, 0));
    send_query(query(maxp, maxp, maxp, maxp, 16384, 16384, maxp, maxp, maxp));
    send_query(query(minp, minp, 0, 0, -16384, -16384, minp, minp, 0));
    send_query(query(minp, maxp, maxp, maxp, 0, 16384, maxp, minp, maxp));
    send_query(query(maxp, minp, maxp, 0, 0, -16384, minp, maxp, maxp));
    send_query(query(0, 0, 65536, 65536, 16384, 0, 196608, 0, 65536));
    send_query(query(0, 0, 65536, 65536, 16384, 0, 196608, 0, 65535));
    send_query(query(0, 0, 65536, 65536, 0, 16384, 0, 300000, 10));
    send_query(query(100, -100, 65536, 65536, 11585, 11585, 103, -98, 1));
    send_query(query(maxp - 5, maxp - 5, maxp, maxp, 16384, 0, maxp, maxp, maxp));
    send_query(query(minp + 5, minp + 5, maxp, maxp, 16384, 0, minp, minp, maxp));
    send_query(query(0, 0, 65536, 65536, 16384, 16384, 100000, 100000, 200000));
    send_query(query(0, 0, 65536, 0, 16384, 0, 70000, 4, 10000));
    send_query(query(0, 0, 1000, 1000, 16384, 0, 1006, 0, 6));

    settle_and_write(32'd0);
    send_query(query(0, 0, 1000, 1000, 16384, 0, 1001, 0, 6));
    send_query(query(0, 0, 1000, 1000, 16384, 0, 0, 0, 0));
    settle_and_write(32'hFFFF_FFFF);
    send_query(query(0, 0, 1000, 1000, 16384, 0, 1006, 0, 6));
    send_query(query(0, 0, 1000, 1000, 16384, 0, 66536, 0, 65536));
    settle_and_write(32'd36);
    send_query(query(0, 0, 1000, 1000, 16384, 0, 1006, 0, 6));
    send_query(query(0, 0, 1000, 1000, 16384, 0, 1005, 0, 6));

    settle_and_write(32'd43);
    for (int i = 0; i < 500; i++) send_query(random_query());
    steady = 1;
    for (int i = 0; i < 400; i++) send_query(random_query());
    steady = 0;
    settle_and_write(32'd0);
    for (int i = 0; i < 300; i++) send_query(random_query());
    settle_and_write(32'hFFFF_FFFF);
    for (int i = 0; i < 200; i++) send_query(random_query());
    settle_and_write($urandom);
    for (int i = 0; i < 200; i++) send_query(random_query());
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/obcc_pkg.sv
design/oriented_box_circle_collision.sv
tb/obcc_checker.sv
tb/tb.sv
